// ===== rtl/triangle_scanline_span_defines.svh =====
// ---------------------------------------------------------------------------
// Triangle scanline span - assertion macros
// Shared property wrappers clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_DEFINES_SVH

// Same-cycle implication.
`define TSS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define TSS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/tss_pkg.sv =====
// ---------------------------------------------------------------------------
// Triangle scanline span - package
// Shared widths, register indexes, reset values and control flags.
// ---------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int DIM_BITS       = 13;
    localparam int OUT_BITS       = 12;
    localparam int COLOR_BITS     = 32;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 13'd1920;
    localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 13'd1080;
    localparam logic [COLOR_BITS-1:0] COLOR_RST  = 32'hFFFF_D700;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COLOR  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic ok;          // row inside triangle and surface
        logic long_flat;   // long edge horizontal
        logic short_flat;  // chosen short edge horizontal
    } tss_flags_t;

endpackage

`default_nettype wire

// ===== rtl/tss_sort.sv =====
// ---------------------------------------------------------------------------
// Triangle scanline span - sort and edge setup
// Stage 0 sorts the vertices by y; stage 1 picks the edges and forms deltas.
// ---------------------------------------------------------------------------
`default_nettype none

module tss_sort #(
    parameter int C = tss_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic [1:0]                     adv,
    input  logic signed [C-1:0]            ax,
    input  logic signed [C-1:0]            ay,
    input  logic signed [C-1:0]            bx,
    input  logic signed [C-1:0]            by,
    input  logic signed [C-1:0]            cx,
    input  logic signed [C-1:0]            cy,
    input  logic signed [C-1:0]            row,
    input  logic [tss_pkg::DIM_BITS-1:0]   height,
    output logic signed [C-1:0]            long_x0,
    output logic signed [C-1:0]            short_x0,
    output logic signed [C-1:0]            row_out,
    output logic signed [C:0]              long_dx,
    output logic signed [C:0]              long_dr,
    output logic signed [C:0]              short_dx,
    output logic signed [C:0]              short_dr,
    output logic [C-1:0]                   long_dy,
    output logic [C-1:0]                   short_dy,
    output tss_pkg::tss_flags_t            flags
);
    import tss_pkg::*;

    localparam int CW = ((C > DIM_BITS) ? C : DIM_BITS) + 1;

    logic signed [C-1:0] x1a, y1a, x1b, y1b;
    logic signed [C-1:0] x2a, y2a, x2c, y2c;
    logic signed [C-1:0] x3b, y3b, x3c, y3c;

    logic signed [C-1:0] xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg, row0_reg;

    logic signed [C-1:0] sx0, sy0, sx1, sy1;
    logic                upper;
    logic signed [C:0]   ldy_full, sdy_full;
    tss_flags_t          flags_next;

    logic signed [C-1:0] lx0_reg, sx0_reg, row1_reg;
    logic signed [C:0]   ldx_reg, ldr_reg, sdx_reg, sdr_reg;
    logic [C-1:0]        ldy_reg, sdy_reg;
    tss_flags_t          flags_reg;

    // Three-step compare/swap network.
    always_comb
    begin
        {x1a, y1a, x1b, y1b} = (by < ay) ? {bx, by, ax, ay} : {ax, ay, bx, by};
        {x2a, y2a, x2c, y2c} = (cy < y1a) ? {cx, cy, x1a, y1a} : {x1a, y1a, cx, cy};
        {x3b, y3b, x3c, y3c} = (y2c < y1b) ? {x2c, y2c, x1b, y1b} : {x1b, y1b, x2c, y2c};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            xa_reg   <= x2a;
            ya_reg   <= y2a;
            xb_reg   <= x3b;
            yb_reg   <= y3b;
            xc_reg   <= x3c;
            yc_reg   <= y3c;
            row0_reg <= row;
        end
    end

    // Pick the short edge: upper half above the middle vertex, lower otherwise.
    always_comb
    begin
        upper = row0_reg < yb_reg;
        if (upper)
        begin
            sx0 = xa_reg;
            sy0 = ya_reg;
            sx1 = xb_reg;
            sy1 = yb_reg;
        end
        else
        begin
            sx0 = xb_reg;
            sy0 = yb_reg;
            sx1 = xc_reg;
            sy1 = yc_reg;
        end
        ldy_full = (C+1)'(yc_reg) - (C+1)'(ya_reg);
        sdy_full = (C+1)'(sy1) - (C+1)'(sy0);
        flags_next.ok = (row0_reg >= ya_reg) && (row0_reg <= yc_reg)
                     && !row0_reg[C-1]
                     && (CW'(row0_reg) < $signed(CW'(height)));
        flags_next.long_flat  = (yc_reg == ya_reg);
        flags_next.short_flat = (sy1 == sy0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            lx0_reg   <= xa_reg;
            sx0_reg   <= sx0;
            row1_reg  <= row0_reg;
            ldx_reg   <= (C+1)'(xc_reg) - (C+1)'(xa_reg);
            ldr_reg   <= (C+1)'(row0_reg) - (C+1)'(ya_reg);
            sdx_reg   <= (C+1)'(sx1) - (C+1)'(sx0);
            sdr_reg   <= (C+1)'(row0_reg) - (C+1)'(sy0);
            ldy_reg   <= ldy_full[C-1:0];
            sdy_reg   <= sdy_full[C-1:0];
            flags_reg <= flags_next;
        end
    end

    assign long_x0  = lx0_reg;
    assign short_x0 = sx0_reg;
    assign row_out  = row1_reg;
    assign long_dx  = ldx_reg;
    assign long_dr  = ldr_reg;
    assign short_dx = sdx_reg;
    assign short_dr = sdr_reg;
    assign long_dy  = ldy_reg;
    assign short_dy = sdy_reg;
    assign flags    = flags_reg;

endmodule

`default_nettype wire

// ===== rtl/tss_div.sv =====
// ---------------------------------------------------------------------------
// Triangle scanline span - pipelined dual divider
// Two lanes of restoring division, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module tss_div #(
    parameter int C      = tss_pkg::COORD_BITS_DEF,
    parameter int SIDE_W = 3 * tss_pkg::COORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic [C:0]              adv,
    input  logic signed [2*C+1:0]   num_long,
    input  logic signed [2*C+1:0]   num_short,
    input  logic [C-1:0]            den_long,
    input  logic [C-1:0]            den_short,
    input  logic [SIDE_W-1:0]       side_in,
    input  tss_pkg::tss_flags_t     flags_in,
    output logic [C-1:0]            quo_long,
    output logic [C-1:0]            quo_short,
    output logic                    neg_long,
    output logic                    neg_short,
    output logic [SIDE_W-1:0]       side_out,
    output tss_pkg::tss_flags_t     flags_out
);
    import tss_pkg::*;

    localparam int RW = 2 * C;
    localparam int PW = 2 * C + 2;

    logic signed [PW-1:0] num_in [0:1];
    logic [C-1:0]         den_in [0:1];

    logic [RW-1:0] rem_reg [0:C][0:1];
    logic [C-1:0]  quo_reg [0:C][0:1];
    logic [C-1:0]  den_reg [0:C][0:1];
    logic          neg_reg [0:C][0:1];
    logic [SIDE_W-1:0] side_reg [0:C];
    tss_flags_t        flags_reg [0:C];

    logic [PW-1:0] mag   [0:1];
    logic [RW-1:0] trial [1:C][0:1];
    logic          take  [1:C][0:1];
    logic [RW-1:0] rem_next [1:C][0:1];
    logic [C-1:0]  quo_next [1:C][0:1];

    assign num_in[0] = num_long;
    assign num_in[1] = num_short;
    assign den_in[0] = den_long;
    assign den_in[1] = den_short;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag[l] = num_in[l][PW-1] ? PW'(-num_in[l]) : PW'(num_in[l]);
        end
        for (int k = 1; k <= C; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[k][l]    = {{C{1'b0}}, den_reg[k-1][l]} << (C - k);
                take[k][l]     = rem_reg[k-1][l] >= trial[k][l];
                rem_next[k][l] = take[k][l] ? (rem_reg[k-1][l] - trial[k][l])
                                            : rem_reg[k-1][l];
                quo_next[k][l] = quo_reg[k-1][l];
                quo_next[k][l][C-k] = take[k][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 0: split sign and magnitude.
        if (adv[0])
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= mag[l][RW-1:0];
                quo_reg[0][l] <= '0;
                den_reg[0][l] <= den_in[l];
                neg_reg[0][l] <= num_in[l][PW-1];
            end
            side_reg[0]  <= side_in;
            flags_reg[0] <= flags_in;
        end
        // Stages 1..C: resolve one quotient bit each, MSB first.
        for (int k = 1; k <= C; k++)
        begin
            if (adv[k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                    den_reg[k][l] <= den_reg[k-1][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
                side_reg[k]  <= side_reg[k-1];
                flags_reg[k] <= flags_reg[k-1];
            end
        end
    end

    assign quo_long  = quo_reg[C][0];
    assign quo_short = quo_reg[C][1];
    assign neg_long  = neg_reg[C][0];
    assign neg_short = neg_reg[C][1];
    assign side_out  = side_reg[C];
    assign flags_out = flags_reg[C];

endmodule

`default_nettype wire

// ===== rtl/triangle_scanline_span.sv =====
// ---------------------------------------------------------------------------
// Triangle scanline span - top level
// Per-row span of a flat-filled triangle, clipped to the surface.
// ---------------------------------------------------------------------------
// Usage:
//   Input request: three vertices and a row on in_valid/in_ready. Output
//   request: span_valid, span_row, span_x_start, span_x_end and span_color on
//   out_valid/out_ready. One result comes back for every request, in order.
//   From acceptance to out_valid a request passes through sort, edge setup,
//   multiply, COORD_BITS + 1 divider stages (one quotient bit per stage),
//   edge add, min/max and clip.
//   Throughput is one request per cycle while the output is not stalled; the
//   bit-serial divider pipeline sets the depth, not the rate.
//   Stalls: each stage holds its request only while the stage after it is
//   full and blocked, so bubbles collapse and in_ready stays high until
//   every stage holds a request and out_ready is low.
//   Reset: all stages empty, registers back to 1920 x 1080, color FFFFD700.
//   Write cfg_we/cfg_index/cfg_data only while the pipeline is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_scanline_span #(
    parameter int COORD_BITS = tss_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tss_pkg::COLOR_BITS-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       vertex_a_x,
    input  logic signed [COORD_BITS-1:0]       vertex_a_y,
    input  logic signed [COORD_BITS-1:0]       vertex_b_x,
    input  logic signed [COORD_BITS-1:0]       vertex_b_y,
    input  logic signed [COORD_BITS-1:0]       vertex_c_x,
    input  logic signed [COORD_BITS-1:0]       vertex_c_y,
    input  logic signed [COORD_BITS-1:0]       scanline_row,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               span_valid,
    output logic [tss_pkg::OUT_BITS-1:0]       span_row,
    output logic [tss_pkg::OUT_BITS-1:0]       span_x_start,
    output logic [tss_pkg::OUT_BITS-1:0]       span_x_end,
    output logic [tss_pkg::COLOR_BITS-1:0]     span_color
);
    import tss_pkg::*;

    `include "triangle_scanline_span_defines.svh"

    localparam int C      = COORD_BITS;
    localparam int PW     = 2 * C + 2;
    localparam int SIDE_W = 3 * C;
    localparam int CW     = ((C > DIM_BITS) ? C : DIM_BITS) + 1;
    // Stage map: sort, setup, multiply, divider (C+1), edge add, min/max, clip.
    localparam int S_MUL  = 2;
    localparam int S_DIV  = 3;
    localparam int S_FIX  = S_DIV + C + 1;
    localparam int S_MM   = S_FIX + 1;
    localparam int S_OUT  = S_MM + 1;
    localparam int DEPTH  = S_OUT + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    logic [COLOR_BITS-1:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            color_reg  <= COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_COLOR:  color_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage advance. A stage moves when it is empty
    // or the next stage moves, so bubbles are squeezed out.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] move;

    always_comb
    begin
        move[DEPTH-1] = !vld_reg[DEPTH-1] || out_ready;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            move[i] = !vld_reg[i] || move[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (move[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (move[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = move[0];
    assign out_valid = vld_reg[DEPTH-1];

    // ------------------------------------------------------------------
    // Sort and edge setup (stages 0 and 1)
    // ------------------------------------------------------------------
    logic signed [C-1:0] long_x0, short_x0, row_s1;
    logic signed [C:0]   long_dx, long_dr, short_dx, short_dr;
    logic [C-1:0]        long_dy, short_dy;
    tss_flags_t          flags_s1;

    tss_sort #(
        .C (C)
    ) u_sort (
        .clk      (clk),
        .adv      (move[1:0]),
        .ax       (vertex_a_x),
        .ay       (vertex_a_y),
        .bx       (vertex_b_x),
        .by       (vertex_b_y),
        .cx       (vertex_c_x),
        .cy       (vertex_c_y),
        .row      (scanline_row),
        .height   (height_reg),
        .long_x0  (long_x0),
        .short_x0 (short_x0),
        .row_out  (row_s1),
        .long_dx  (long_dx),
        .long_dr  (long_dr),
        .short_dx (short_dx),
        .short_dr (short_dr),
        .long_dy  (long_dy),
        .short_dy (short_dy),
        .flags    (flags_s1)
    );

    // ------------------------------------------------------------------
    // Multiply: dx * (row - y0) for both edges
    // ------------------------------------------------------------------
    logic signed [PW-1:0] lprod_reg, sprod_reg;
    logic [C-1:0]         ldy_reg, sdy_reg;
    logic [SIDE_W-1:0]    side_mul_reg;
    tss_flags_t           flags_mul_reg;

    always_ff @(posedge clk)
    begin
        if (move[S_MUL])
        begin
            lprod_reg     <= PW'(long_dx) * PW'(long_dr);
            sprod_reg     <= PW'(short_dx) * PW'(short_dr);
            ldy_reg       <= long_dy;
            sdy_reg       <= short_dy;
            side_mul_reg  <= {long_x0, short_x0, row_s1};
            flags_mul_reg <= flags_s1;
        end
    end

    // ------------------------------------------------------------------
    // Divide: truncating quotient as sign and magnitude
    // ------------------------------------------------------------------
    logic [C-1:0]      lquo, squo;
    logic              lneg, sneg;
    logic [SIDE_W-1:0] side_div;
    tss_flags_t        flags_div;

    tss_div #(
        .C      (C),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .adv       (move[S_FIX-1:S_DIV]),
        .num_long  (lprod_reg),
        .num_short (sprod_reg),
        .den_long  (ldy_reg),
        .den_short (sdy_reg),
        .side_in   (side_mul_reg),
        .flags_in  (flags_mul_reg),
        .quo_long  (lquo),
        .quo_short (squo),
        .neg_long  (lneg),
        .neg_short (sneg),
        .side_out  (side_div),
        .flags_out (flags_div)
    );

    // ------------------------------------------------------------------
    // Edge add: x0 +/- quotient; a horizontal edge keeps its start x.
    // The crossing lies between the edge ends, so C bits hold it.
    // ------------------------------------------------------------------
    logic [C-1:0] dx0_l, dx0_s;
    logic [C-1:0] e_long, e_short;

    assign dx0_l   = side_div[3*C-1:2*C];
    assign dx0_s   = side_div[2*C-1:C];
    assign e_long  = flags_div.long_flat  ? dx0_l : (lneg ? dx0_l - lquo : dx0_l + lquo);
    assign e_short = flags_div.short_flat ? dx0_s : (sneg ? dx0_s - squo : dx0_s + squo);

    logic signed [C-1:0] el_reg, es_reg, row_fix_reg;
    logic                ok_fix_reg;

    always_ff @(posedge clk)
    begin
        if (move[S_FIX])
        begin
            el_reg      <= $signed(e_long);
            es_reg      <= $signed(e_short);
            row_fix_reg <= $signed(side_div[C-1:0]);
            ok_fix_reg  <= flags_div.ok;
        end
    end

    // ------------------------------------------------------------------
    // Order the two crossings
    // ------------------------------------------------------------------
    logic signed [C-1:0] lo_reg, hi_reg, row_mm_reg;
    logic                ok_mm_reg;

    always_ff @(posedge clk)
    begin
        if (move[S_MM])
        begin
            lo_reg     <= (el_reg < es_reg) ? el_reg : es_reg;
            hi_reg     <= (el_reg < es_reg) ? es_reg : el_reg;
            row_mm_reg <= row_fix_reg;
            ok_mm_reg  <= ok_fix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Clip to the surface and drop spans wholly off screen
    // ------------------------------------------------------------------
    logic signed [CW-1:0] lo_w, hi_w, w_s;
    logic                 off_screen, ok_clip;
    logic [CW-1:0]        lo_clip, hi_clip;

    always_comb
    begin
        lo_w       = CW'(lo_reg);
        hi_w       = CW'(hi_reg);
        w_s        = $signed(CW'(width_reg));
        off_screen = hi_reg[C-1] || (lo_w >= w_s);
        ok_clip    = ok_mm_reg && !off_screen;
        lo_clip    = lo_reg[C-1] ? '0 : lo_w;
        hi_clip    = (hi_w >= w_s) ? CW'(w_s - CW'(1)) : hi_w;
    end

    logic                  sv_reg;
    logic [OUT_BITS-1:0]   srow_reg, sxs_reg, sxe_reg;
    logic [COLOR_BITS-1:0] scol_reg;

    always_ff @(posedge clk)
    begin
        if (move[S_OUT])
        begin
            sv_reg   <= ok_clip;
            srow_reg <= OUT_BITS'($unsigned(row_mm_reg));
            sxs_reg  <= ok_clip ? OUT_BITS'(lo_clip) : '0;
            sxe_reg  <= ok_clip ? OUT_BITS'(hi_clip) : '0;
            scol_reg <= ok_clip ? color_reg : '0;
        end
    end

    assign span_valid   = sv_reg;
    assign span_row     = srow_reg;
    assign span_x_start = sxs_reg;
    assign span_x_end   = sxe_reg;
    assign span_color   = scol_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TSS_ASSERT_NOW(a_span_order, out_valid && span_valid, span_x_start <= span_x_end, "span start past end")
    `TSS_ASSERT_NOW(a_span_clip, out_valid && span_valid, DIM_BITS'(span_x_end) < width_reg, "span end beyond surface")
    `TSS_ASSERT_NOW(a_span_blank, out_valid && !span_valid, span_x_start == '0 && span_x_end == '0 && span_color == '0, "invalid span not blanked")
    `TSS_ASSERT_NOW(a_stall_full, !in_ready, (&vld_reg) && !out_ready, "input blocked with a free stage")

endmodule

`default_nettype wire
